// ===== rtl/median_filter_7x7_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef MEDIAN_FILTER_7X7_TOP_ASSERT_SVH
`define MEDIAN_FILTER_7X7_TOP_ASSERT_SVH

// Clocked assertion that is off while reset is held.
`define MF7_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("median filter assertion failed");

// Clocked assertion that also holds through reset.
`define MF7_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("median filter assertion failed");

`endif

// ===== rtl/mf7_pkg.sv =====
`default_nettype none
package mf7_pkg;
    localparam int WIDTH  = 128;
    localparam int HEIGHT = 128;
    localparam int RADIUS = 3;
    localparam int SIDE   = 2 * RADIUS + 1;
    localparam int WIN    = SIDE * SIDE;
    localparam int MID    = (WIN - 1) / 2;
    localparam int LAG    = RADIUS * WIDTH + RADIUS;
    localparam int TOTAL  = WIDTH * HEIGHT;
    localparam int POS_W  = $clog2(TOTAL + 1);
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);
    localparam int RANK_W = $clog2(WIN);
    localparam int PIX_W  = 8;
    localparam int LB_W   = (SIDE - 1) * PIX_W;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic vld;
        logic border;
        logic last;
    } t_ctl;
endpackage
`default_nettype wire

// ===== rtl/median_filter_7x7_top.sv =====
`default_nettype none
// Throughput: one beat per cycle while no result is stalled at the outputs;
// the line buffer is read and written back each beat.
// A result appears 3 rows plus 3 pixels after its pixel; drain beats push out the tail.
// Reset (synchronous, active low) clears positions and pipeline valids;
// line buffer and window contents are left as they are.
module median_filter_7x7_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_pixel_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_pixel_out,
    output logic            o_frame_last
);
    localparam int PW = mf7_pkg::POS_W;
    localparam int SD = mf7_pkg::SIDE;
    localparam int PX = mf7_pkg::PIX_W;

    logic en, acc, act_p, act_d, act, emit, last, border;
    logic [PW-1:0] r_in, r_out, n_in, n_out;
    logic [mf7_pkg::COL_W-1:0] r_col, n_col, r_ocol, n_ocol;
    logic [mf7_pkg::ROW_W-1:0] r_orow, n_orow;
    logic r_s1_act;
    mf7_pkg::t_pix r_s1_px;
    logic [mf7_pkg::COL_W-1:0] r_s1_addr;
    mf7_pkg::t_ctl r_s1_ctl, r_s2_ctl, med_ctl;
    logic [mf7_pkg::LB_W-1:0] rd_data, wr_data;
    mf7_pkg::t_pix r_win [SD][SD];
    mf7_pkg::t_pix col_new [SD];
    mf7_pkg::t_win win_flat;
    mf7_pkg::t_pix med_pix;

    assign en      = !med_ctl.vld || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;

    // Decide whether the beat advances the frame and releases a result
    always_comb begin
        act_p  = (i_kind == mf7_pkg::KIND_PIXEL) && (r_in < PW'(mf7_pkg::TOTAL));
        act_d  = (i_kind == mf7_pkg::KIND_DRAIN) && (r_in == PW'(mf7_pkg::TOTAL))
                 && (r_out < PW'(mf7_pkg::TOTAL));
        act    = acc && (act_p || act_d);
        emit   = act && (act_d ||
                 ({1'b0, r_in} == ({1'b0, r_out} + (PW+1)'(mf7_pkg::LAG))));
        last   = emit && (r_out == PW'(mf7_pkg::TOTAL - 1));
        border = (r_orow < mf7_pkg::ROW_W'(mf7_pkg::RADIUS))
              || (r_orow > mf7_pkg::ROW_W'(mf7_pkg::HEIGHT - 1 - mf7_pkg::RADIUS))
              || (r_ocol < mf7_pkg::COL_W'(mf7_pkg::RADIUS))
              || (r_ocol > mf7_pkg::COL_W'(mf7_pkg::WIDTH - 1 - mf7_pkg::RADIUS));
        n_in   = r_in;
        n_out  = r_out;
        n_col  = r_col;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (act) begin
            n_col = (r_col == mf7_pkg::COL_W'(mf7_pkg::WIDTH - 1)) ? '0 : r_col + 1'b1;
            if (act_p) begin
                n_in = r_in + 1'b1;
            end
        end
        if (emit) begin
            n_out = r_out + 1'b1;
            if (r_ocol == mf7_pkg::COL_W'(mf7_pkg::WIDTH - 1)) begin
                n_ocol = '0;
                n_orow = r_orow + 1'b1;
            end else begin
                n_ocol = r_ocol + 1'b1;
            end
            if (last) begin
                n_in   = '0;
                n_out  = '0;
                n_ocol = '0;
                n_orow = '0;
            end
        end
    end

    // Hold positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in     <= '0;
            r_out    <= '0;
            r_col    <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r_s1_act <= 1'b0;
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else begin
            r_in   <= n_in;
            r_out  <= n_out;
            r_col  <= n_col;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            if (en) begin
                r_s1_act <= act;
                r_s1_ctl <= '{vld: emit, border: border, last: last};
                // delay control until the window holds the beat's column
                r_s2_ctl <= r_s1_ctl;
            end
        end
    end

    // Register the beat payload while the line buffer is read
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_px   <= (i_kind == mf7_pkg::KIND_PIXEL) ? i_pixel_in : '0;
            r_s1_addr <= r_col;
        end
    end

    mf7_line_buf u_lb (
        .i_clk     (i_clk),
        .i_rd_en   (en),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (en && r_s1_act),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data)
    );

    // Build the new window column, top row first
    always_comb begin
        for (int k = 0; k < SD; k++) begin
            if (k == SD - 1) begin
                col_new[k] = r_s1_px;
            end else begin
                col_new[k] = rd_data[(SD - 2 - k) * PX +: PX];
            end
        end
    end

    assign wr_data = {rd_data[mf7_pkg::LB_W-PX-1:0], r_s1_px};

    // Shift the window left by one column
    always_ff @(posedge i_clk) begin
        if (en && r_s1_act) begin
            for (int k = 0; k < SD; k++) begin
                for (int j = 0; j < SD - 1; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
                r_win[k][SD-1] <= col_new[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < SD; k++) begin
            for (int j = 0; j < SD; j++) begin
                win_flat[k * SD + j] = r_win[k][j];
            end
        end
    end

    mf7_median u_med (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_s2_ctl),
        .i_win   (win_flat),
        .o_ctl   (med_ctl),
        .o_pix   (med_pix)
    );

    assign o_valid      = med_ctl.vld;
    assign o_pixel_out  = med_pix;
    assign o_frame_last = med_ctl.last;
endmodule
`default_nettype wire

// ===== rtl/mf7_line_buf.sv =====
`default_nettype none
module mf7_line_buf (
    input  wire logic                        i_clk,
    input  wire logic                        i_rd_en,
    input  wire logic [mf7_pkg::COL_W-1:0]   i_rd_addr,
    output logic      [mf7_pkg::LB_W-1:0]    o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic [mf7_pkg::COL_W-1:0]   i_wr_addr,
    input  wire logic [mf7_pkg::LB_W-1:0]    i_wr_data
);
    logic [mf7_pkg::LB_W-1:0] mem [mf7_pkg::WIDTH];

    // Write one column of earlier rows
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mf7_median.sv =====
`default_nettype none
module mf7_median (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire mf7_pkg::t_ctl  i_ctl,
    input  wire mf7_pkg::t_win  i_win,
    output mf7_pkg::t_ctl       o_ctl,
    output mf7_pkg::t_pix       o_pix
);
    logic [mf7_pkg::WIN-1:0] r_lt [mf7_pkg::WIN];
    logic [mf7_pkg::WIN-1:0] n_lt [mf7_pkg::WIN];
    logic [mf7_pkg::WIN-1:0] r_hit;
    logic [mf7_pkg::WIN-1:0] n_hit;
    mf7_pkg::t_win r_w2, r_w3;
    mf7_pkg::t_ctl r_c2, r_c3, r_c4;
    mf7_pkg::t_pix r_pix, n_pix;

    // Pairwise order, ties broken by position
    always_comb begin
        for (int i = 0; i < mf7_pkg::WIN; i++) begin
            for (int j = 0; j < mf7_pkg::WIN; j++) begin
                n_lt[i][j] = (i_win[j] < i_win[i]) || ((i_win[j] == i_win[i]) && (j < i));
            end
        end
    end

    // Mark the element whose rank is the middle one
    always_comb begin
        for (int i = 0; i < mf7_pkg::WIN; i++) begin
            n_hit[i] = (mf7_pkg::RANK_W'($countones(r_lt[i])) == mf7_pkg::RANK_W'(mf7_pkg::MID));
        end
    end

    // Pick the median, or the centre pixel at the border
    always_comb begin
        n_pix = '0;
        for (int i = 0; i < mf7_pkg::WIN; i++) begin
            n_pix = n_pix | (r_hit[i] ? r_w3[i] : '0);
        end
        if (r_c3.border) begin
            n_pix = r_w3[mf7_pkg::MID];
        end
    end

    // Advance payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lt  <= n_lt;
            r_w2  <= i_win;
            r_hit <= n_hit;
            r_w3  <= r_w2;
            r_pix <= n_pix;
        end
    end

    // Advance control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
        end else if (i_en) begin
            r_c2 <= i_ctl;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
        end
    end

    assign o_ctl = r_c4;
    assign o_pix = r_pix;
endmodule
`default_nettype wire

// ===== rtl/mf7_checker.sv =====
`default_nettype none
`include "median_filter_7x7_top_assert.svh"
module mf7_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_pixel_out,
    input wire logic       o_frame_last
);
    // Hold a stalled result
    `MF7_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `MF7_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_pixel_out))
    // Drop all results after reset
    `MF7_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_valid)
    // A frame end is never followed at once by another
    `MF7_ASSERT(a_last_gap, i_clk, i_rst_n,
        o_valid && i_ready && o_frame_last |=> !(o_valid && o_frame_last))
    // Hold off an offered beat only behind a stalled result
    `MF7_ASSERT(a_ready_stall, i_clk, i_rst_n, i_valid && !o_ready |-> o_valid && !i_ready)
endmodule
bind median_filter_7x7_top mf7_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pixel_out  (o_pixel_out),
    .o_frame_last (o_frame_last)
);
`default_nettype wire
